// ===== hw/rtl/tsk_pkg.sv =====
// Shared types and constants for the topological sort unit.
// No dependencies; topological_sort_kahn_unit imports this package (tsk_ram does not).
package tsk_pkg;

    localparam int VERTEX_W = 5;
    localparam int COUNT_W  = 6;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;
    localparam int VERTEX_FIELD_LIMIT = 32;

    typedef struct packed {
        logic [VERTEX_W-1:0] edge_from;
        logic [VERTEX_W-1:0] edge_to;
        logic                has_edge;
        logic                last_edge;
    } edge_item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                vertex_valid;
        logic                last_result;
        logic                order_complete;
        logic                edges_dropped;
    } result_item_t;

    typedef logic [COUNT_W-1:0] vertex_count_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_UPD,
        S_ZSCAN,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_UPD,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } state_t;

endpackage

// ===== hw/rtl/tsk_stream_if.sv =====
// Valid/ready stream channel used for edges, results and configuration.
// The payload type is a parameter; the types come from tsk_pkg.
interface tsk_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/topological_sort_kahn_unit.sv =====
// Kahn topological sort unit. Edges are taken one per cycle while idle; the item
// marked last starts the sort, and input and configuration stall until the order is out.
// The sort counts in-degrees over the E stored edges, scans the n vertices for zero
// in-degree, rescans every stored edge for each popped vertex and stops on an empty
// queue; results then go out one at a time, each held until taken (a lone result for an empty order).
// Reset clears the graph and sets vertex_count to 32; RAM contents are not reset.
module topological_sort_kahn_unit
    import tsk_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    tsk_stream_if.sink   edges,
    tsk_stream_if.source results,
    tsk_stream_if.sink   cfg
);
    localparam int VLIM = (MAX_VERTICES < VERTEX_FIELD_LIMIT) ? MAX_VERTICES
                                                              : VERTEX_FIELD_LIMIT;
    localparam int QAW  = (VLIM > 1) ? $clog2(VLIM) : 1;
    localparam int QCW  = $clog2(VLIM + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam logic [COUNT_W-1:0] VLIM_C = COUNT_W'(VLIM);
    localparam logic [ECW-1:0]     EDGE_CAP = ECW'(MAX_EDGES);

    state_t state_reg, state_next;

    vertex_count_t      vcount_reg, vcount_next;
    logic [ECW-1:0]     ecount_reg, ecount_next;
    logic [ECW-1:0]     eidx_reg, eidx_next;
    logic [ECW-1:0]     indeg_reg [VLIM];
    logic [ECW-1:0]     indeg_next [VLIM];
    logic [QCW-1:0]     head_reg, head_next;
    logic [QCW-1:0]     tail_reg, tail_next;
    logic [QCW-1:0]     vidx_reg, vidx_next;
    logic [VERTEX_W-1:0] u_reg, u_next;
    logic               drop_reg, drop_next;
    result_item_t       out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    vertex_count_t       n_eff;
    edge_item_t          in_item;
    logic                in_fire;
    logic                out_fire;
    logic                cfg_fire;
    logic                edge_ok;

    logic                e_we, e_re;
    logic [2*VERTEX_W-1:0] e_rdata;
    logic [VERTEX_W-1:0] e_src, e_dst;
    logic                e_in_range;

    logic                q_we, q_re;
    logic [QAW-1:0]      q_raddr;
    logic [VERTEX_W-1:0] q_wdata, q_rdata;

    logic [QAW-1:0]      deg_idx;
    logic [ECW-1:0]      deg_rd;

    assign n_eff    = (vcount_reg > VLIM_C) ? VLIM_C : vcount_reg;
    assign in_item  = edges.payload;
    assign in_fire  = edges.valid && edges.ready;
    assign out_fire = results.valid && results.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign edge_ok  = (COUNT_W'(in_item.edge_from) < n_eff)
                   && (COUNT_W'(in_item.edge_to) < n_eff)
                   && (ecount_reg < EDGE_CAP);

    assign e_src      = e_rdata[2*VERTEX_W-1:VERTEX_W];
    assign e_dst      = e_rdata[VERTEX_W-1:0];
    assign e_in_range = (COUNT_W'(e_src) < n_eff) && (COUNT_W'(e_dst) < n_eff);

    // One read port on the in-degree table: the zero scan walks it by index,
    // the edge passes address it by the edge target.
    assign deg_idx = (state_reg == S_ZSCAN) ? vidx_reg[QAW-1:0] : e_dst[QAW-1:0];
    assign deg_rd  = indeg_reg[deg_idx];

    tsk_ram #(
        .WIDTH (2 * VERTEX_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (ecount_reg[EAW-1:0]),
        .wdata ({in_item.edge_from, in_item.edge_to}),
        .re    (e_re),
        .raddr (eidx_reg[EAW-1:0]),
        .rdata (e_rdata)
    );

    tsk_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (VLIM)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[QAW-1:0]),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_item.last_edge)
                begin
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                state_next = (eidx_reg == ecount_reg) ? S_ZSCAN : S_CNT_UPD;
            end
            S_CNT_UPD:
            begin
                state_next = S_CNT_RD;
            end
            S_ZSCAN:
            begin
                if (COUNT_W'(vidx_reg) == n_eff)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = (tail_reg == '0) ? S_EMIT_LD : S_EMIT_RD;
                end
                else
                begin
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = (eidx_reg == ecount_reg) ? S_POP : S_SCAN_UPD;
            end
            S_SCAN_UPD:
            begin
                state_next = S_SCAN_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                state_next = S_EMIT_HOLD;
            end
            S_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    state_next = out_reg.last_result ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and memory control.
    always_comb
    begin
        e_we    = 1'b0;
        e_re    = 1'b0;
        q_re    = 1'b0;
        q_raddr = head_reg[QAW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                e_we = in_fire && in_item.has_edge && edge_ok;
            end
            S_CNT_RD, S_SCAN_RD:
            begin
                e_re = (eidx_reg != ecount_reg);
            end
            S_POP:
            begin
                q_re = (head_reg != tail_reg);
            end
            S_EMIT_RD:
            begin
                q_re    = 1'b1;
                q_raddr = vidx_reg[QAW-1:0];
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    assign edges.ready     = (state_reg == S_IDLE);
    assign cfg.ready       = (state_reg == S_IDLE);
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    // Datapath registers.
    always_comb
    begin
        vcount_next    = vcount_reg;
        ecount_next    = ecount_reg;
        eidx_next      = eidx_reg;
        indeg_next     = indeg_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        vidx_next      = vidx_reg;
        u_next         = u_reg;
        drop_next      = drop_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_we           = 1'b0;
        q_wdata        = e_dst;

        if (cfg_fire)
        begin
            vcount_next = cfg.payload;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_item.has_edge)
                    begin
                        if (edge_ok)
                        begin
                            ecount_next = ecount_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    eidx_next = '0;
                end
            end
            S_CNT_RD:
            begin
                vidx_next = '0;
            end
            S_CNT_UPD:
            begin
                if (e_in_range)
                begin
                    indeg_next[deg_idx] = deg_rd + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                eidx_next = eidx_reg + 1'b1;
            end
            S_ZSCAN:
            begin
                if (COUNT_W'(vidx_reg) != n_eff)
                begin
                    if (deg_rd == '0)
                    begin
                        q_we      = 1'b1;
                        q_wdata   = VERTEX_W'(vidx_reg);
                        tail_next = tail_reg + 1'b1;
                    end
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            S_POP:
            begin
                vidx_next = '0;
            end
            S_POP_WAIT:
            begin
                u_next    = q_rdata;
                head_next = head_reg + 1'b1;
                eidx_next = '0;
            end
            S_SCAN_UPD:
            begin
                if (e_src == u_reg && e_in_range && deg_rd != '0)
                begin
                    indeg_next[deg_idx] = deg_rd - 1'b1;
                    if (deg_rd == ECW'(1))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                eidx_next = eidx_reg + 1'b1;
            end
            S_EMIT_LD:
            begin
                // An empty order still produces one transaction, marked invalid.
                out_next.vertex         = (tail_reg == '0) ? '0 : q_rdata;
                out_next.vertex_valid   = (tail_reg != '0);
                out_next.last_result    = (tail_reg == '0)
                                       || (QCW'(vidx_reg + 1'b1) == tail_reg);
                out_next.order_complete = (COUNT_W'(tail_reg) == n_eff);
                out_next.edges_dropped  = drop_reg;
                out_valid_next          = 1'b1;
            end
            S_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    vidx_next      = vidx_reg + 1'b1;
                    if (out_reg.last_result)
                    begin
                        ecount_next = '0;
                        head_next   = '0;
                        tail_next   = '0;
                        drop_next   = 1'b0;
                        for (int k = 0; k < VLIM; k++)
                        begin
                            indeg_next[k] = '0;
                        end
                    end
                end
            end
            default:
            begin
                q_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VERTEX_COUNT_RESET;
            ecount_reg    <= '0;
            eidx_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            vidx_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < VLIM; k++)
            begin
                indeg_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            ecount_reg    <= ecount_next;
            eidx_reg      <= eidx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            vidx_reg      <= vidx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            indeg_reg     <= indeg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        out_reg <= out_next;
    end
endmodule

// ===== hw/rtl/tsk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
